FILE: hdl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants of the integer to ASCII formatter
// Format codes, sequencer states, the character word passed to the pair
// packer, and the digit to ASCII table.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam logic [1:0] ACT_DEC = 2'd0;
   localparam logic [1:0] ACT_HEX = 2'd1;
   localparam logic [1:0] ACT_BIN = 2'd2;

   localparam int VALUE_W   = 64;
   localparam int BCD_W     = 80;           // 20 decimal digits
   localparam int BCD_NIBS  = BCD_W / 4;
   localparam int CNT_W     = 7;

   localparam logic [CNT_W-1:0] CONV_STEPS = 7'd64;
   localparam logic [CNT_W-1:0] DEC_DIGITS = 7'd20;
   localparam logic [CNT_W-1:0] HEX_DIGITS = 7'd16;
   localparam logic [CNT_W-1:0] BIN_DIGITS = 7'd64;
   localparam logic [CNT_W-1:0] CNT_ONE    = 7'd1;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_MINUS = 8'h2d;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_PREFIX,
      ST_SCAN
   } state_type;

   // one character from the sequencer to the pair packer
   typedef struct packed {
      logic       valid;
      logic       tail;     // final character of the text
      logic [7:0] code;
   } char_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      case (d)
         4'h0: c = 8'h30;
         4'h1: c = 8'h31;
         4'h2: c = 8'h32;
         4'h3: c = 8'h33;
         4'h4: c = 8'h34;
         4'h5: c = 8'h35;
         4'h6: c = 8'h36;
         4'h7: c = 8'h37;
         4'h8: c = 8'h38;
         4'h9: c = 8'h39;
         4'ha: c = 8'h61;
         4'hb: c = 8'h62;
         4'hc: c = 8'h63;
         4'hd: c = 8'h64;
         4'he: c = 8'h65;
         default: c = 8'h66;
      endcase
      return c;
   endfunction

endpackage

FILE: hdl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: 64-bit value to ASCII text
// Signed decimal, 0x hex or 0b binary text, emitted as character pairs.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low; busy then stays high
// until the final character is formed. Decimal runs a 64-step shift-and-add-3
// binary to BCD conversion, one bit a cycle, then scans 20 digits. Hex sends a
// 0x prefix and scans 16 digits, binary a 0b prefix and 64 digits; the scan
// takes one digit a cycle and skips leading zeros, but the units digit prints.
// Pairs appear on the rsp_ ports for one cycle each, flagged by rsp_strobe, and
// must be taken when shown. A format code of 3 is dropped and busy stays low.
module integer_to_ascii_formatter
   import itoa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_action,
   input  logic [63:0]  req_value,
   output logic         rsp_strobe,
   output logic [7:0]   rsp_first_char,
   output logic [7:0]   rsp_second_char,
   output logic         rsp_second_valid,
   output logic         rsp_last
);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [BCD_W-1:0]     dig_ff, dig_in;
   logic [VALUE_W-1:0]   src_ff, src_in;
   logic [1:0]           mode_ff, mode_in;
   logic                 neg_ff, neg_in;
   logic                 pfx_ff, pfx_in;
   logic                 lead_ff, lead_in;

   logic [BCD_W-1:0]     adj;
   logic [VALUE_W-1:0]   mag;
   logic [3:0]           cur_digit;
   logic                 cnt_last;
   char_type             chr;

   // add-3 correction on every BCD digit before the shift
   always_comb begin
      for (int i = 0; i < BCD_NIBS; i++) begin
         if (dig_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = dig_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = dig_ff[4*i +: 4];
         end
      end
   end

   assign mag       = req_value[VALUE_W-1] ? (~req_value + 64'd1) : req_value;
   assign cur_digit = (mode_ff == ACT_BIN) ? {3'b000, dig_ff[BCD_W-1]}
                                           : dig_ff[BCD_W-1 -: 4];
   assign cnt_last  = (cnt_ff == CNT_ONE);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      dig_in    = dig_ff;
      src_in    = src_ff;
      mode_in   = mode_ff;
      neg_in    = neg_ff;
      pfx_in    = pfx_ff;
      lead_in   = lead_ff;
      chr.valid = 1'b0;
      chr.tail  = 1'b0;
      chr.code  = CH_ZERO;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in = req_action;
               lead_in = 1'b0;
               case (req_action) inside
                  ACT_DEC: begin
                     src_in   = mag;
                     neg_in   = req_value[VALUE_W-1];
                     dig_in   = '0;
                     cnt_in   = CONV_STEPS;
                     pfx_in   = 1'b1;
                     state_in = ST_CONV;
                  end
                  ACT_HEX, ACT_BIN: begin
                     dig_in   = {req_value, {(BCD_W-VALUE_W){1'b0}}};
                     neg_in   = 1'b0;
                     pfx_in   = 1'b0;
                     cnt_in   = (req_action == ACT_HEX) ? HEX_DIGITS : BIN_DIGITS;
                     state_in = ST_PREFIX;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CONV: begin
            dig_in = {adj[BCD_W-2:0], src_ff[VALUE_W-1]};
            src_in = {src_ff[VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_ONE;
            if (cnt_last) begin
               cnt_in   = DEC_DIGITS;
               state_in = neg_ff ? ST_PREFIX : ST_SCAN;
            end
         end
         ST_PREFIX: begin
            chr.valid = 1'b1;
            if (!pfx_ff) begin
               chr.code = CH_ZERO;
               pfx_in   = 1'b1;
            end else begin
               case (mode_ff)
                  ACT_HEX: chr.code = CH_X;
                  ACT_BIN: chr.code = CH_B;
                  default: chr.code = CH_MINUS;
               endcase
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // skip leading zeros, but the units digit always prints
            chr.valid = lead_ff || (cur_digit != 4'd0) || cnt_last;
            chr.tail  = cnt_last;
            chr.code  = digit_char(cur_digit);
            if (chr.valid) begin
               lead_in = 1'b1;
            end
            if (mode_ff == ACT_BIN) begin
               dig_in = {dig_ff[BCD_W-2:0], 1'b0};
            end else begin
               dig_in = {dig_ff[BCD_W-5:0], 4'b0000};
            end
            cnt_in = cnt_ff - CNT_ONE;
            if (cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      dig_ff  <= dig_in;
      src_ff  <= src_in;
      mode_ff <= mode_in;
      neg_ff  <= neg_in;
      pfx_ff  <= pfx_in;
      lead_ff <= lead_in;
   end

   assign busy = (state_ff != ST_IDLE);

   itoa_pair u_pair (
      .clock            (clock),
      .reset            (reset),
      .chr              (chr),
      .rsp_strobe       (rsp_strobe),
      .rsp_first_char   (rsp_first_char),
      .rsp_second_char  (rsp_second_char),
      .rsp_second_valid (rsp_second_valid),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   // the closing word always coincides with the sequencer back in idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy)
      else $error("final word while still busy");

   // a padded word can only close the text
   a_pad_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_second_valid |-> rsp_last)
      else $error("padded word not last");

   // unused format code is dropped
   a_drop: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action != ACT_DEC && req_action != ACT_HEX
      && req_action != ACT_BIN |=> !busy)
      else $error("unused format code started work");
`endif

endmodule

FILE: hdl/itoa_pair.sv
// ----------------------------------------------------------------------------
// itoa_pair: character pair packer
// Collects the character stream into pairs and drives the registered result
// word with its strobe, padding an odd final character.
// ----------------------------------------------------------------------------
module itoa_pair
   import itoa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  char_type   chr,
   output logic       rsp_strobe,
   output logic [7:0] rsp_first_char,
   output logic [7:0] rsp_second_char,
   output logic       rsp_second_valid,
   output logic       rsp_last
);

   logic       hold_ff, hold_in;
   logic [7:0] held_ff, held_in;
   logic       strobe_ff, strobe_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic       sv_ff, sv_in;
   logic       last_ff, last_in;

   always_comb begin
      hold_in   = hold_ff;
      held_in   = held_ff;
      strobe_in = 1'b0;
      first_in  = first_ff;
      second_in = second_ff;
      sv_in     = sv_ff;
      last_in   = last_ff;
      if (chr.valid) begin
         if (hold_ff) begin
            strobe_in = 1'b1;
            first_in  = held_ff;
            second_in = chr.code;
            sv_in     = 1'b1;
            last_in   = chr.tail;
            hold_in   = 1'b0;
         end else if (chr.tail) begin
            // odd length: lone character closes the text
            strobe_in = 1'b1;
            first_in  = chr.code;
            second_in = 8'h00;
            sv_in     = 1'b0;
            last_in   = 1'b1;
         end else begin
            held_in = chr.code;
            hold_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         hold_ff   <= hold_in;
         strobe_ff <= strobe_in;
      end
      held_ff   <= held_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      sv_ff     <= sv_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_first_char   = first_ff;
   assign rsp_second_char  = second_ff;
   assign rsp_second_valid = sv_ff;
   assign rsp_last         = last_ff;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the integer to ASCII formatter
// Drives signed decimal, hex, binary and unused-format words through the
// start/busy handshake. A local predictor builds the expected character
// pairs, and each strobed pair is checked field by field against the oldest.
// ----------------------------------------------------------------------------
module tb_top;
   import itoa_pkg::*;

   localparam logic [1:0] ACT_NONE = 2'd3;   // unused format, dropped by the block
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_WORDS  = 440;
   localparam int CALM_WORDS    = 60;
   localparam int SETTLE_CYCLES = 200;

   typedef struct {
      logic [1:0]  action;
      logic [63:0] value;
      int          gap;     // idle cycles after this word
      bit          drain;   // hold off until every pair due has arrived
   } word_type;

   typedef struct packed {
      logic [7:0] first_char;
      logic [7:0] second_char;
      logic       second_valid;
      logic       last;
   } pair_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        start      = 1'b0;
   logic [1:0]  req_action = ACT_DEC;
   logic [63:0] req_value  = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [7:0]  rsp_first_char;
   logic [7:0]  rsp_second_char;
   logic        rsp_second_valid;
   logic        rsp_last;

   word_type words_pending[$];
   pair_type pairs_due[$];
   bit       taken      = 1'b0;
   bit       calm       = 1'b0;
   int       idle_left  = 0;
   int       n_mismatch = 0;
   int       n_pairs    = 0;
   int       cycle_count = 0;
   int       n_fmt [4]  = '{0, 0, 0, 0};

   integer_to_ascii_formatter i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_first_char   (rsp_first_char),
      .rsp_second_char  (rsp_second_char),
      .rsp_second_valid (rsp_second_valid),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // expected text of one word, split into pairs
   function automatic void format_pairs(input logic [1:0] act, input logic [63:0] val);
      logic [7:0]  text [0:65];
      logic [7:0]  digits [0:63];
      logic [63:0] mag;
      logic [63:0] radix;
      logic [63:0] d;
      int          len;
      int          nd;
      pair_type    pr;
      len = 0;
      nd  = 0;
      mag = val;
      case (act)
         ACT_DEC: begin
            radix = 64'd10;
            if (val[63]) begin
               text[0] = CH_MINUS;
               len = 1;
               mag = ~val + 64'd1;
            end
         end
         ACT_HEX: begin
            radix = 64'd16;
            text[0] = CH_ZERO;
            text[1] = CH_X;
            len = 2;
         end
         ACT_BIN: begin
            radix = 64'd2;
            text[0] = CH_ZERO;
            text[1] = CH_B;
            len = 2;
         end
         default: return;
      endcase
      do begin
         d = mag % radix;
         digits[nd] = (d < 64'd10) ? CH_ZERO + d[7:0] : 8'h61 + d[7:0] - 8'd10;
         mag = mag / radix;
         nd++;
      end while (mag != 64'd0);
      for (int k = 0; k < nd; k++) text[len + k] = digits[nd - 1 - k];
      len += nd;
      for (int p = 0; 2 * p < len; p++) begin
         pr.first_char   = text[2 * p];
         pr.second_valid = (2 * p + 1 < len);
         pr.second_char  = pr.second_valid ? text[2 * p + 1] : 8'h00;
         pr.last         = (2 * p + 2 >= len);
         pairs_due.push_back(pr);
      end
   endfunction

   task automatic add_word(input logic [1:0] act, input logic [63:0] val, input bit drain);
      word_type w;
      w.action = act;
      w.value  = val;
      w.drain  = drain;
      w.gap    = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      words_pending.push_back(w);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pairs still due", cycle_count,
                  pairs_due.size());
         $display("** integer_to_ascii_formatter: FAILED **");
         $finish;
      end
   end

   // driver: inputs move on the falling edge
   always @(negedge clock) begin
      word_type w;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !taken) begin
         // word still offered, hold it
      end else if (idle_left > 0 || words_pending.size() == 0 ||
                   (words_pending[0].drain && pairs_due.size() != 0)) begin
         if (idle_left > 0) idle_left <= idle_left - 1;
         start      <= 1'b0;
         req_action <= 2'($urandom);
         req_value  <= {$urandom, $urandom};
      end else begin
         w = words_pending.pop_front();
         idle_left  <= w.gap;
         start      <= 1'b1;
         req_action <= w.action;
         req_value  <= w.value;
      end
   end

   // monitor: check pairs first, then predict for a word taken at this edge
   always @(posedge clock) begin
      pair_type got;
      pair_type want;
      taken <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_strobe) begin
            got = {rsp_first_char, rsp_second_char, rsp_second_valid, rsp_last};
            n_pairs++;
            if (pairs_due.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("cycle %0d: pair with none due: first %h second %h valid %b last %b",
                           cycle_count, got.first_char, got.second_char,
                           got.second_valid, got.last);
            end else begin
               want = pairs_due.pop_front();
               if (got.first_char !== want.first_char ||
                   got.second_char !== want.second_char ||
                   got.second_valid !== want.second_valid || got.last !== want.last) begin
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display({"cycle %0d: expected first %h second %h valid %b last %b,",
                               " got first %h second %h valid %b last %b"}, cycle_count,
                              want.first_char, want.second_char, want.second_valid,
                              want.last, got.first_char, got.second_char,
                              got.second_valid, got.last);
               end
            end
         end
         if (start && !busy) begin
            format_pairs(req_action, req_value);
            n_fmt[req_action]++;
         end
      end
   end

   initial begin
      logic [63:0] v;
      logic [1:0]  act;
      int          r;
      int          leftover;

      // edge values, odd and even text lengths, the longest text, dropped format
      add_word(ACT_DEC, 64'd0, 1'b0);
      add_word(ACT_DEC, 64'd1, 1'b0);
      add_word(ACT_DEC, 64'd10, 1'b0);
      add_word(ACT_DEC, 64'd9, 1'b0);
      add_word(ACT_DEC, '1, 1'b0);
      add_word(ACT_DEC, 64'h7fff_ffff_ffff_ffff, 1'b0);
      add_word(ACT_DEC, 64'h8000_0000_0000_0000, 1'b0);
      add_word(ACT_DEC, 64'hffff_ffff_ffff_fff6, 1'b0);
      add_word(ACT_HEX, 64'd0, 1'b0);
      add_word(ACT_HEX, 64'hf, 1'b0);
      add_word(ACT_HEX, 64'h10, 1'b0);
      add_word(ACT_HEX, '1, 1'b0);
      add_word(ACT_HEX, 64'h0123_4567_89ab_cdef, 1'b0);
      add_word(ACT_HEX, 64'h8000_0000_0000_0000, 1'b0);
      add_word(ACT_BIN, 64'd0, 1'b0);
      add_word(ACT_BIN, 64'd1, 1'b0);
      add_word(ACT_BIN, 64'd2, 1'b0);
      add_word(ACT_BIN, '1, 1'b0);
      add_word(ACT_BIN, 64'h8000_0000_0000_0000, 1'b0);
      add_word(ACT_BIN, 64'h5555_5555_5555_5555, 1'b0);
      add_word(ACT_NONE, '1, 1'b0);
      add_word(ACT_NONE, 64'd0, 1'b0);
      add_word(ACT_DEC, 64'd12345, 1'b0);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
         case ($urandom_range(0, 4))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 1000));
            2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            3: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 2));
            default: v = -64'($urandom_range(1, 100000));
         endcase
         r = $urandom_range(0, 19);
         act = (r == 0) ? ACT_NONE : 2'(r % 3);
         add_word(act, v, i == 0 || i == 150 || i == 300);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (words_pending.size() != 0 || start) @(posedge clock);
      while (pairs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      leftover = pairs_due.size();
      $display("words taken: %0d decimal, %0d hex, %0d binary, %0d unused format",
               n_fmt[0], n_fmt[1], n_fmt[2], n_fmt[3]);
      $display("pairs checked: %0d, mismatches: %0d, pairs never seen: %0d",
               n_pairs, n_mismatch, leftover);
      if (n_mismatch == 0 && leftover == 0) begin
         $display("** integer_to_ascii_formatter: PASSED **");
      end else begin
         $display("** integer_to_ascii_formatter: FAILED **");
      end
      $finish;
   end

endmodule

FILE: integer_to_ascii_formatter.f
hdl/itoa_pkg.sv
hdl/itoa_pair.sv
hdl/integer_to_ascii_formatter.sv
verif/tb_top.sv
